[src/mfc_pkg.sv]
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared constants and types for the mixed FNV-1a vector checksum: hash and
// mixing constants, partial product step codes and the controller command word.
// ----------------------------------------------------------------------------
package mfc_pkg;

	// FNV-1a 64-bit constants
	localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF29CE484222325;
	// prime 0x100000001B3 split into a short low part and a single high bit
	localparam logic [8:0]  FNV_PRIME_LO     = 9'h1B3;
	localparam int          FNV_PRIME_SHIFT  = 40;

	// golden-ratio mixing constant
	localparam logic [63:0] GOLDEN_MIX       = 64'h9E3779B97F4A7C15;

	// number of byte rounds per word
	localparam int          NUM_BYTES        = 8;

	// partial product steps of the 64 x 64 mixing multiply (low 64 bits kept)
	typedef enum logic [1:0] {
		MIX_LL = 2'd0,   // low x low, full 64-bit product
		MIX_LH = 2'd1,   // low x high, added into upper half
		MIX_HL = 2'd2    // high x low, added into upper half
	} mix_step_t;

	// commands from controller to datapath
	typedef struct packed {
		logic      load;      // capture the incoming word and start a fresh hash
		logic      mix_en;    // run one partial product step
		mix_step_t mix_step;
		logic      round;     // one FNV-1a byte round
		logic      fold;      // XOR the word hash into the accumulator
		logic      emit;      // load the folded checksum and restart the accumulator
	} mfc_cmd_t;

endpackage

[src/mfc_dp.sv]
// ----------------------------------------------------------------------------
// mfc_dp
// Datapath: word mixing through one shared 32 x 32 multiplier in three partial
// product steps, byte-serial FNV-1a rounds, accumulator and output register.
// ----------------------------------------------------------------------------
module mfc_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  mfc_pkg::mfc_cmd_t cmd,
	input  logic [63:0]      element_bits,
	output logic signed [31:0] checksum
);
	import mfc_pkg::*;

	logic [63:0] x_q;     // word after folding in its upper half
	logic [63:0] m_q;     // mixed word, shifted down one byte per round
	logic [63:0] h_q;     // per-word FNV-1a hash
	logic [63:0] acc_q;   // running accumulator
	logic [31:0] sum_q;   // output checksum register

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] rnd_t;
	logic [63:0] rnd_h;
	logic [63:0] acc_new;

	// operand selection for the shared multiplier
	always_comb begin
		case (cmd.mix_step)
			MIX_LL: begin
				mul_a = x_q[31:0];
				mul_b = GOLDEN_MIX[31:0];
			end
			MIX_LH: begin
				mul_a = x_q[31:0];
				mul_b = GOLDEN_MIX[63:32];
			end
			MIX_HL: begin
				mul_a = x_q[63:32];
				mul_b = GOLDEN_MIX[31:0];
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = GOLDEN_MIX[31:0];
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// one byte round: xor in the low byte, multiply by the prime
	assign rnd_t = h_q ^ {56'd0, m_q[7:0]};
	assign rnd_h = 64'(rnd_t * 64'(FNV_PRIME_LO)) + (rnd_t << FNV_PRIME_SHIFT);

	assign acc_new = acc_q ^ h_q;

	// word, mix, hash and output checksum registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= element_bits ^ {32'd0, element_bits[63:32]};
			h_q <= FNV_OFFSET_BASIS;
		end
		if (cmd.mix_en) begin
			if (cmd.mix_step == MIX_LL) begin
				m_q <= mul_p;
			end else begin
				m_q[63:32] <= m_q[63:32] + mul_p[31:0];
			end
		end
		if (cmd.round) begin
			h_q <= rnd_h;
			m_q <= m_q >> 8;
		end
		if (cmd.fold && cmd.emit) begin
			sum_q <= acc_new[63:32] ^ acc_new[31:0];
		end
	end

	// accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= FNV_OFFSET_BASIS;
		end else if (cmd.fold) begin
			acc_q <= cmd.emit ? FNV_OFFSET_BASIS : acc_new;
		end
	end

	assign checksum = signed'(sum_q);

endmodule

[src/mfc_ctrl.sv]
// ----------------------------------------------------------------------------
// mfc_ctrl
// Controller: sequences word capture, three mixing steps, eight byte rounds and
// the fold, and owns both handshakes.
// ----------------------------------------------------------------------------
module mfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              last_element,
	output logic              out_valid,
	input  logic              out_stall,
	output mfc_pkg::mfc_cmd_t cmd
);
	import mfc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MIX,
		S_ROUND,
		S_FOLD
	} state_t;

	state_t      state_q;
	mix_step_t   step_q;
	logic [2:0]  byte_q;
	logic        last_q;
	logic        out_valid_q;
	logic        in_acc;
	logic        out_busy;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	// result register still holds a word nobody has taken
	assign out_busy = out_valid_q && out_stall;
	assign out_valid = out_valid_q;

	// commands decoded from state
	always_comb begin
		cmd          = '0;
		cmd.mix_step = step_q;
		case (state_q)
			S_IDLE:  cmd.load   = in_acc;
			S_MIX:   cmd.mix_en = 1'b1;
			S_ROUND: cmd.round  = 1'b1;
			S_FOLD: begin
				cmd.fold = !(last_q && out_busy);
				cmd.emit = last_q;
			end
			default: cmd = '0;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= MIX_LL;
			byte_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set by the fold of a last element, cleared when taken
			if (state_q == S_FOLD && last_q && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						last_q  <= last_element;
						step_q  <= MIX_LL;
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					case (step_q)
						MIX_LL:  step_q <= MIX_LH;
						MIX_LH:  step_q <= MIX_HL;
						default: begin
							step_q  <= MIX_LL;
							byte_q  <= '0;
							state_q <= S_ROUND;
						end
					endcase
				end
				S_ROUND: begin
					byte_q <= byte_q + 3'd1;
					if (byte_q == 3'(NUM_BYTES - 1)) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (!(last_q && out_busy)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/mixed_fnv1a_vector_checksum.sv]
// ----------------------------------------------------------------------------
// mixed_fnv1a_vector_checksum
// A result word becomes valid when the fold of the last element completes.
// A new element is taken only once the previous one has gone through the three
// partial products of the mixing multiply on one 32 x 32 multiplier, the eight byte rounds and the fold.
// A waiting result blocks only the fold of the next last element, until taken.
// Reset (arst_n low) clears the sequencer, the result valid and returns the
// accumulator to the FNV offset basis.
// ----------------------------------------------------------------------------
module mixed_fnv1a_vector_checksum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [63:0]        element_bits,
	input  logic               last_element,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] checksum
);
	import mfc_pkg::*;

	mfc_cmd_t cmd;

	// sequencer
	mfc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.last_element (last_element),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cmd          (cmd)
	);

	// hashing datapath
	mfc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.element_bits (element_bits),
		.checksum     (checksum)
	);

endmodule

[src/mfc_checker.sv]
// ----------------------------------------------------------------------------
// mfc_checker
// Port-level checks on the checksum block, bound to the top level.
// ----------------------------------------------------------------------------
module mfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] checksum
);

	// result word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(checksum))
		else $error("result word dropped or changed while stalled");

	// one element at a time: input is stalled right after a word is taken
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again while a word is in flight");

	// a result appears only at the end of a word's processing
	a_out_from_fold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without a word in flight");

	// no result can be produced faster than the mixing and rounds allow
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##3 !$rose(out_valid))
		else $error("result raised too soon after a word was taken");

endmodule

bind mixed_fnv1a_vector_checksum mfc_checker u_mfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.checksum  (checksum)
);
